// File: src/radio_duty_cycle_power_governor_defines.svh
// Assertion macros shared by the radio duty-cycle power governor RTL.
`ifndef RADIO_DUTY_CYCLE_POWER_GOVERNOR_DEFINES_SVH
`define RADIO_DUTY_CYCLE_POWER_GOVERNOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RDCPG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RDCPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rdcpg_pkg.sv
// Package with types, register codes and reset values of the power governor.
`timescale 1ns / 1ps
package rdcpg_pkg;

  localparam int IntervalW = 16;
  localparam int PctW      = 7;
  localparam int TickW     = 32;
  localparam int AddrW     = 5;
  localparam int DataW     = 32;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_ULTRA  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_SCAN_INTERVAL_LOW   = 3'd0,
    REG_SCAN_INTERVAL_ULTRA = 3'd1,
    REG_ADV_INTERVAL_LOW    = 3'd2,
    REG_ADV_INTERVAL_ULTRA  = 3'd3,
    REG_DUTY_LOW            = 3'd4,
    REG_DUTY_ULTRA          = 3'd5,
    REG_BATT_ULTRA_THR      = 3'd6,
    REG_BATT_LOW_THR        = 3'd7
  } reg_idx_t;

  localparam logic [IntervalW-1:0] RstScanIntervalLow   = 16'd5000;
  localparam logic [IntervalW-1:0] RstScanIntervalUltra = 16'd15000;
  localparam logic [IntervalW-1:0] RstAdvIntervalLow    = 16'd2000;
  localparam logic [IntervalW-1:0] RstAdvIntervalUltra  = 16'd10000;
  localparam logic [PctW-1:0]      RstDutyLow           = 7'd50;
  localparam logic [PctW-1:0]      RstDutyUltra         = 7'd20;
  localparam logic [PctW-1:0]      RstBattUltraThr      = 7'd20;
  localparam logic [PctW-1:0]      RstBattLowThr        = 7'd50;

  typedef struct packed {
    logic [IntervalW-1:0] scan_interval_low;
    logic [IntervalW-1:0] scan_interval_ultra;
    logic [IntervalW-1:0] adv_interval_low;
    logic [IntervalW-1:0] adv_interval_ultra;
    logic [PctW-1:0]      duty_low;
    logic [PctW-1:0]      duty_ultra;
    logic [PctW-1:0]      batt_ultra_thr;
    logic [PctW-1:0]      batt_low_thr;
  } cfg_t;

  typedef struct packed {
    logic [IntervalW-1:0] interval;
    logic [PctW-1:0]      duty;
  } chan_cfg_t;

endpackage

// File: src/rdcpg_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module rdcpg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdcpg_pkg::AddrW-1:0]   paddr,
  input  logic [rdcpg_pkg::DataW-1:0]   pwdata,
  output logic [rdcpg_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  output rdcpg_pkg::cfg_t               cfg
);

  rdcpg_pkg::cfg_t     cfg_r;
  rdcpg_pkg::cfg_t     cfg_nxt;
  rdcpg_pkg::reg_idx_t idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = rdcpg_pkg::reg_idx_t'(paddr[rdcpg_pkg::AddrW-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        rdcpg_pkg::REG_SCAN_INTERVAL_LOW:   cfg_nxt.scan_interval_low   = pwdata[15:0];
        rdcpg_pkg::REG_SCAN_INTERVAL_ULTRA: cfg_nxt.scan_interval_ultra = pwdata[15:0];
        rdcpg_pkg::REG_ADV_INTERVAL_LOW:    cfg_nxt.adv_interval_low    = pwdata[15:0];
        rdcpg_pkg::REG_ADV_INTERVAL_ULTRA:  cfg_nxt.adv_interval_ultra  = pwdata[15:0];
        rdcpg_pkg::REG_DUTY_LOW:            cfg_nxt.duty_low            = pwdata[6:0];
        rdcpg_pkg::REG_DUTY_ULTRA:          cfg_nxt.duty_ultra          = pwdata[6:0];
        rdcpg_pkg::REG_BATT_ULTRA_THR:      cfg_nxt.batt_ultra_thr      = pwdata[6:0];
        rdcpg_pkg::REG_BATT_LOW_THR:        cfg_nxt.batt_low_thr        = pwdata[6:0];
        default:                            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rdcpg_pkg::REG_SCAN_INTERVAL_LOW:   prdata = {16'd0, cfg_r.scan_interval_low};
      rdcpg_pkg::REG_SCAN_INTERVAL_ULTRA: prdata = {16'd0, cfg_r.scan_interval_ultra};
      rdcpg_pkg::REG_ADV_INTERVAL_LOW:    prdata = {16'd0, cfg_r.adv_interval_low};
      rdcpg_pkg::REG_ADV_INTERVAL_ULTRA:  prdata = {16'd0, cfg_r.adv_interval_ultra};
      rdcpg_pkg::REG_DUTY_LOW:            prdata = {25'd0, cfg_r.duty_low};
      rdcpg_pkg::REG_DUTY_ULTRA:          prdata = {25'd0, cfg_r.duty_ultra};
      rdcpg_pkg::REG_BATT_ULTRA_THR:      prdata = {25'd0, cfg_r.batt_ultra_thr};
      rdcpg_pkg::REG_BATT_LOW_THR:        prdata = {25'd0, cfg_r.batt_low_thr};
      default:                            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_interval_low   <= rdcpg_pkg::RstScanIntervalLow;
      cfg_r.scan_interval_ultra <= rdcpg_pkg::RstScanIntervalUltra;
      cfg_r.adv_interval_low    <= rdcpg_pkg::RstAdvIntervalLow;
      cfg_r.adv_interval_ultra  <= rdcpg_pkg::RstAdvIntervalUltra;
      cfg_r.duty_low            <= rdcpg_pkg::RstDutyLow;
      cfg_r.duty_ultra          <= rdcpg_pkg::RstDutyUltra;
      cfg_r.batt_ultra_thr      <= rdcpg_pkg::RstBattUltraThr;
      cfg_r.batt_low_thr        <= rdcpg_pkg::RstBattLowThr;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/rdcpg_mode.sv
// Power mode register with user write and battery downgrade.
`timescale 1ns / 1ps
module rdcpg_mode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic                          set_mode,
  input  logic [1:0]                    requested_mode,
  input  logic                          battery_valid,
  input  logic [rdcpg_pkg::PctW-1:0]    battery_pct,
  input  rdcpg_pkg::cfg_t               cfg,
  output rdcpg_pkg::mode_t              mode_nxt
);

  rdcpg_pkg::mode_t mode_r;
  rdcpg_pkg::mode_t mode_user;

  always_comb begin
    mode_user = mode_r;
    if (set_mode && (requested_mode <= 2'(rdcpg_pkg::MODE_ULTRA))) begin
      mode_user = rdcpg_pkg::mode_t'(requested_mode);
    end
    mode_nxt = mode_user;
    if (battery_valid) begin
      if (battery_pct < cfg.batt_ultra_thr) begin
        mode_nxt = rdcpg_pkg::MODE_ULTRA;
      end else if (battery_pct < cfg.batt_low_thr) begin
        mode_nxt = rdcpg_pkg::MODE_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rdcpg_pkg::MODE_NORMAL;
    end else if (upd) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// File: src/rdcpg_chan.sv
// Window timer and duty decision for one radio channel.
`timescale 1ns / 1ps
module rdcpg_chan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  logic [rdcpg_pkg::TickW-1:0]   now_ms,
  input  rdcpg_pkg::chan_cfg_t          ccfg,
  output logic                          on
);

  logic [rdcpg_pkg::TickW-1:0]     start_r;
  logic [rdcpg_pkg::TickW-1:0]     start_nxt;
  logic                            active_r;
  logic                            active_nxt;
  logic [rdcpg_pkg::TickW-1:0]     elapsed;
  logic                            restart;
  logic [22:0]                     span_prod;
  logic [16:0]                     elapsed_inc;
  logic [23:0]                     elapsed_scaled;
  logic                            in_span;

  // elapsed < (interval*duty)/100 is the same as 100*(elapsed+1) <= interval*duty.
  assign elapsed        = now_ms - start_r;
  assign restart        = elapsed >= {16'd0, ccfg.interval};
  assign span_prod      = 23'(ccfg.interval) * 23'(ccfg.duty);
  assign elapsed_inc    = {1'b0, elapsed[15:0]} + 17'd1;
  assign elapsed_scaled = 24'(elapsed_inc) * 24'd100;
  assign in_span        = elapsed_scaled <= {1'b0, span_prod};

  assign on         = restart | (active_r & in_span);
  assign active_nxt = restart | (active_r & in_span);
  assign start_nxt  = restart ? now_ms : start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      active_r <= 1'b1;
    end else if (upd) begin
      start_r  <= start_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// File: src/radio_duty_cycle_power_governor.sv
// Top level of the radio duty-cycle power governor.
`timescale 1ns / 1ps
// Usage:
// Each input transaction carries a millisecond tick, an optional mode write
// and an optional battery reading. Each one yields exactly one result
// transaction with the scan and advertise enables and the resulting mode.
// An input register captures the transaction; the mode and both channel
// windows are evaluated from it combinationally and written into the result
// register when the transaction advances, which a receiver stall can delay.
// Throughput is one transaction per cycle while the receiver does not stall, set by
// the single evaluation stage whose state feedback closes within that cycle.
// When the receiver stalls, the result register holds its transaction and
// the input register may still take one more; in_stall rises only when both
// are full and the receiver is stalling.
// Reset is synchronous and active low: it empties both stages, returns the
// mode to normal, sets both channels active with their windows starting at
// zero and loads the configuration registers with their default values.
// Configuration writes through the APB-style port take effect at once; the user must make
// them only while no transaction is in flight, as the block does not enforce this.
`include "radio_duty_cycle_power_governor_defines.svh"
module radio_duty_cycle_power_governor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rdcpg_pkg::TickW-1:0]   in_now_ms,
  input  logic                          in_set_mode,
  input  logic [1:0]                    in_requested_mode,
  input  logic                          in_battery_valid,
  input  logic [rdcpg_pkg::PctW-1:0]    in_battery_pct,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_scan_enable,
  output logic                          out_adv_enable,
  output logic [1:0]                    out_mode_now,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdcpg_pkg::AddrW-1:0]   paddr,
  input  logic [rdcpg_pkg::DataW-1:0]   pwdata,
  output logic [rdcpg_pkg::DataW-1:0]   prdata,
  output logic                          pready
);

  rdcpg_pkg::cfg_t                 cfg;
  rdcpg_pkg::chan_cfg_t            scan_ccfg;
  rdcpg_pkg::chan_cfg_t            adv_ccfg;
  rdcpg_pkg::mode_t                mode_nxt;

  logic                            s1_valid_r;
  logic [rdcpg_pkg::TickW-1:0]     s1_now_r;
  logic                            s1_set_mode_r;
  logic [1:0]                      s1_req_mode_r;
  logic                            s1_batt_valid_r;
  logic [rdcpg_pkg::PctW-1:0]      s1_batt_pct_r;

  logic                            out_valid_r;
  logic                            out_scan_r;
  logic                            out_adv_r;
  logic [1:0]                      out_mode_r;

  logic                            advance;
  logic                            s1_load;
  logic                            chan_upd;
  logic                            is_low;
  logic                            scan_on;
  logic                            adv_on;
  logic                            scan_res;
  logic                            adv_res;

  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~advance;
  assign s1_load  = in_valid & ~in_stall;

  assign out_valid       = out_valid_r;
  assign out_scan_enable = out_scan_r;
  assign out_adv_enable  = out_adv_r;
  assign out_mode_now    = out_mode_r;

  rdcpg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rdcpg_mode u_mode (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd            (advance),
    .set_mode       (s1_set_mode_r),
    .requested_mode (s1_req_mode_r),
    .battery_valid  (s1_batt_valid_r),
    .battery_pct    (s1_batt_pct_r),
    .cfg            (cfg),
    .mode_nxt       (mode_nxt)
  );

  assign is_low   = (mode_nxt == rdcpg_pkg::MODE_LOW);
  assign chan_upd = advance & (mode_nxt != rdcpg_pkg::MODE_NORMAL);

  always_comb begin
    scan_ccfg.interval = is_low ? cfg.scan_interval_low : cfg.scan_interval_ultra;
    scan_ccfg.duty     = is_low ? cfg.duty_low : cfg.duty_ultra;
    adv_ccfg.interval  = is_low ? cfg.adv_interval_low : cfg.adv_interval_ultra;
    adv_ccfg.duty      = is_low ? cfg.duty_low : cfg.duty_ultra;
  end

  rdcpg_chan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (chan_upd),
    .now_ms (s1_now_r),
    .ccfg   (scan_ccfg),
    .on     (scan_on)
  );

  rdcpg_chan u_adv (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (chan_upd),
    .now_ms (s1_now_r),
    .ccfg   (adv_ccfg),
    .on     (adv_on)
  );

  assign scan_res = (mode_nxt == rdcpg_pkg::MODE_NORMAL) | scan_on;
  assign adv_res  = (mode_nxt == rdcpg_pkg::MODE_NORMAL) | adv_on;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_now_r        <= in_now_ms;
      s1_set_mode_r   <= in_set_mode;
      s1_req_mode_r   <= in_requested_mode;
      s1_batt_valid_r <= in_battery_valid;
      s1_batt_pct_r   <= in_battery_pct;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_scan_r <= scan_res;
      out_adv_r  <= adv_res;
      out_mode_r <= 2'(mode_nxt);
    end
  end

  `RDCPG_ASSERT_IMPL(a_stall_only_full, in_stall, s1_valid_r && out_valid_r && out_stall,
                     "input stalled while a stage is free")
  `RDCPG_ASSERT_IMPL(a_normal_both_on,
                     out_valid && (out_mode_now == 2'(rdcpg_pkg::MODE_NORMAL)),
                     out_scan_enable && out_adv_enable,
                     "normal mode result with a channel off")
  `RDCPG_ASSERT_NEXT(a_batt_ultra,
                     advance && s1_batt_valid_r && (s1_batt_pct_r < cfg.batt_ultra_thr),
                     out_valid && (out_mode_now == 2'(rdcpg_pkg::MODE_ULTRA)),
                     "low battery did not force ultra-low mode")

endmodule

// File: verif/governor_tb_pkg.sv
// Transaction types and result scoreboard for the power governor testbench.
`timescale 1ns / 1ps
package governor_tb_pkg;
  import rdcpg_pkg::*;

  typedef struct packed {
    logic [TickW-1:0] now_ms;
    logic             set_mode;
    logic [1:0]       requested_mode;
    logic             battery_valid;
    logic [PctW-1:0]  battery_pct;
  } poll_t;

  typedef struct packed {
    logic       scan_enable;
    logic       adv_enable;
    logic [1:0] mode_now;
  } enables_t;

  class enable_scoreboard;
    cfg_t             cfg;
    mode_t            mode;
    logic [TickW-1:0] scan_start;
    logic [TickW-1:0] adv_start;
    bit               scan_open;
    bit               adv_open;
    enables_t         pending_enables[$];
    int               errors;

    function new();
      cfg.scan_interval_low   = RstScanIntervalLow;
      cfg.scan_interval_ultra = RstScanIntervalUltra;
      cfg.adv_interval_low    = RstAdvIntervalLow;
      cfg.adv_interval_ultra  = RstAdvIntervalUltra;
      cfg.duty_low            = RstDutyLow;
      cfg.duty_ultra          = RstDutyUltra;
      cfg.batt_ultra_thr      = RstBattUltraThr;
      cfg.batt_low_thr        = RstBattLowThr;
      mode       = MODE_NORMAL;
      scan_start = '0;
      adv_start  = '0;
      scan_open  = 1'b1;
      adv_open   = 1'b1;
      errors     = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [DataW-1:0] value);
      case (idx)
        REG_SCAN_INTERVAL_LOW: begin
          cfg.scan_interval_low = value[IntervalW-1:0];
        end
        REG_SCAN_INTERVAL_ULTRA: begin
          cfg.scan_interval_ultra = value[IntervalW-1:0];
        end
        REG_ADV_INTERVAL_LOW: begin
          cfg.adv_interval_low = value[IntervalW-1:0];
        end
        REG_ADV_INTERVAL_ULTRA: begin
          cfg.adv_interval_ultra = value[IntervalW-1:0];
        end
        REG_DUTY_LOW: begin
          cfg.duty_low = value[PctW-1:0];
        end
        REG_DUTY_ULTRA: begin
          cfg.duty_ultra = value[PctW-1:0];
        end
        REG_BATT_ULTRA_THR: begin
          cfg.batt_ultra_thr = value[PctW-1:0];
        end
        default: begin
          cfg.batt_low_thr = value[PctW-1:0];
        end
      endcase
    endfunction

    function bit window_step(logic [TickW-1:0] now, logic [IntervalW-1:0] interval,
                             logic [PctW-1:0] duty, inout logic [TickW-1:0] start,
                             inout bit active);
      logic [TickW-1:0] elapsed;
      logic [TickW-1:0] span;
      elapsed = now - start;
      if (elapsed >= 32'(interval)) begin
        start  = now;
        active = 1'b1;
        return 1'b1;
      end
      if (active) begin
        span = (32'(interval) * 32'(duty)) / 32'd100;
        if (elapsed < span) return 1'b1;
        active = 1'b0;
      end
      return 1'b0;
    endfunction

    function void note_poll(poll_t p);
      enables_t             e;
      logic [IntervalW-1:0] scan_ivl;
      logic [IntervalW-1:0] adv_ivl;
      logic [PctW-1:0]      duty;
      if (p.set_mode && p.requested_mode <= MODE_ULTRA) mode = mode_t'(p.requested_mode);
      if (p.battery_valid) begin
        if (p.battery_pct < cfg.batt_ultra_thr) begin
          mode = MODE_ULTRA;
        end else if (p.battery_pct < cfg.batt_low_thr) begin
          mode = MODE_LOW;
        end
      end
      e.scan_enable = 1'b1;
      e.adv_enable  = 1'b1;
      if (mode != MODE_NORMAL) begin
        if (mode == MODE_LOW) begin
          scan_ivl = cfg.scan_interval_low;
          adv_ivl  = cfg.adv_interval_low;
          duty     = cfg.duty_low;
        end else begin
          scan_ivl = cfg.scan_interval_ultra;
          adv_ivl  = cfg.adv_interval_ultra;
          duty     = cfg.duty_ultra;
        end
        e.scan_enable = window_step(p.now_ms, scan_ivl, duty, scan_start, scan_open);
        e.adv_enable  = window_step(p.now_ms, adv_ivl, duty, adv_start, adv_open);
      end
      e.mode_now = mode;
      pending_enables.push_back(e);
    endfunction

    function void check_enables(enables_t got);
      enables_t want;
      if (pending_enables.size() == 0) begin
        $error("result transaction with no expectation pending");
        errors++;
        return;
      end
      want = pending_enables.pop_front();
      if (got.scan_enable !== want.scan_enable) begin
        $error("scan_enable: expected %0b, got %0b", want.scan_enable, got.scan_enable);
        errors++;
      end
      if (got.adv_enable !== want.adv_enable) begin
        $error("adv_enable: expected %0b, got %0b", want.adv_enable, got.adv_enable);
        errors++;
      end
      if (got.mode_now !== want.mode_now) begin
        $error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
        errors++;
      end
    endfunction

    function bit drained();
      return pending_enables.size() == 0;
    endfunction
  endclass

endpackage

// File: verif/tb.sv
// Top-level testbench for the radio duty-cycle power governor.
`timescale 1ns / 1ps
module tb;
  import rdcpg_pkg::*;
  import governor_tb_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int NumPhases     = 14;
  localparam int PollsPerPhase = 100;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_kind_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [TickW-1:0]   in_now_ms;
  logic               in_set_mode;
  logic [1:0]         in_requested_mode;
  logic               in_battery_valid;
  logic [PctW-1:0]    in_battery_pct;
  logic               out_valid;
  logic               out_stall;
  logic               out_scan_enable;
  logic               out_adv_enable;
  logic [1:0]         out_mode_now;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;

  enable_scoreboard sb = new();
  logic [TickW-1:0] tick;
  int               step_max;
  int               burst_left;

  radio_duty_cycle_power_governor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_now_ms        (in_now_ms),
    .in_set_mode      (in_set_mode),
    .in_requested_mode(in_requested_mode),
    .in_battery_valid (in_battery_valid),
    .in_battery_pct   (in_battery_pct),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scan_enable  (out_scan_enable),
    .out_adv_enable   (out_adv_enable),
    .out_mode_now     (out_mode_now),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_enables({out_scan_enable, out_adv_enable, out_mode_now});
    end
  end

  initial begin : result_stall
    stall_kind_t kind;
    int          left;
    int          phase;
    out_stall <= 1'b0;
    kind = STALL_NONE;
    left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        kind = stall_kind_t'($urandom_range(0, 3));
        left = $urandom_range(50, 300);
      end
      left--;
      phase++;
      case (kind)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        STALL_HEAVY: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= (phase % 4 < 2);
        end
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic poll_t poll_item(logic [TickW-1:0] now, logic set, logic [1:0] req,
                                      logic bv, logic [PctW-1:0] pct);
    poll_t p;
    p.now_ms         = now;
    p.set_mode       = set;
    p.requested_mode = req;
    p.battery_valid  = bv;
    p.battery_pct    = pct;
    return p;
  endfunction

  function automatic poll_t random_poll();
    poll_t p;
    case ($urandom_range(0, 39))
      0: begin
        tick = $urandom;
      end
      1: begin
        tick = 32'hFFFF_FF00 + $urandom_range(0, 255);
      end
      default: begin
        tick = tick + $urandom_range(0, step_max);
      end
    endcase
    p.now_ms         = tick;
    p.set_mode       = ($urandom_range(0, 9) == 0);
    p.requested_mode = 2'($urandom_range(0, 3));
    p.battery_valid  = ($urandom_range(0, 6) == 0);
    p.battery_pct    = 7'($urandom_range(0, 127));
    return p;
  endfunction

  task automatic send_poll(poll_t p);
    in_valid          <= 1'b1;
    in_now_ms         <= p.now_ms;
    in_set_mode       <= p.set_mode;
    in_requested_mode <= p.requested_mode;
    in_battery_valid  <= p.battery_valid;
    in_battery_pct    <= p.battery_pct;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_poll(p);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 30);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (!sb.drained()) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Upper data bits beyond the register width are sometimes filled with noise.
  task automatic cfg_write(reg_idx_t idx, logic [DataW-1:0] value);
    logic [DataW-1:0] junk;
    junk = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      if (idx <= REG_ADV_INTERVAL_ULTRA) begin
        value = {junk[DataW-1:IntervalW], value[IntervalW-1:0]};
      end else begin
        value = {junk[DataW-1:PctW], value[PctW-1:0]};
      end
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic program_config(int setting);
    reg_idx_t         idx;
    logic [DataW-1:0] val;
    bit               is_interval;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      is_interval = (idx <= REG_ADV_INTERVAL_ULTRA);
      if (setting == 0) begin
        val = '0;
      end else if (setting == 1) begin
        val = is_interval ? 32'd65535 : 32'd127;
      end else if (is_interval) begin
        case ($urandom_range(0, 7))
          0: val = 32'd0;
          1: val = 32'd65535;
          2: val = $urandom_range(1, 65535);
          default: val = $urandom_range(1, 300);
        endcase
      end else begin
        case ($urandom_range(0, 5))
          0: val = 32'd0;
          1: val = 32'd100;
          2: val = 32'd127;
          default: val = $urandom_range(0, 100);
        endcase
      end
      cfg_write(idx, val);
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_now_ms         <= '0;
    in_set_mode       <= 1'b0;
    in_requested_mode <= '0;
    in_battery_valid  <= 1'b0;
    in_battery_pct    <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    tick = '0;
    step_max = 50;
    burst_left = 5;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_poll(poll_item(32'd0, 1'b0, 2'd0, 1'b0, 7'd0));
    send_poll(poll_item(32'd1, 1'b1, 2'd3, 1'b0, 7'd0));
    send_poll(poll_item(32'd100, 1'b1, MODE_LOW, 1'b0, 7'd0));
    send_poll(poll_item(32'd1500, 1'b0, 2'd0, 1'b0, 7'd0));
    send_poll(poll_item(32'd2600, 1'b0, 2'd0, 1'b0, 7'd0));
    send_poll(poll_item(32'd5100, 1'b0, 2'd0, 1'b0, 7'd0));
    send_poll(poll_item(32'd5200, 1'b0, 2'd0, 1'b1, 7'd127));
    send_poll(poll_item(32'd5300, 1'b0, 2'd0, 1'b1, 7'd20));
    send_poll(poll_item(32'd5400, 1'b0, 2'd0, 1'b1, 7'd19));
    send_poll(poll_item(32'd5500, 1'b0, 2'd0, 1'b1, 7'd49));
    send_poll(poll_item(32'd5600, 1'b1, MODE_NORMAL, 1'b1, 7'd50));
    send_poll(poll_item(32'd5700, 1'b1, MODE_NORMAL, 1'b1, 7'd0));
    send_poll(poll_item(32'hFFFF_FFFF, 1'b0, 2'd0, 1'b0, 7'd0));
    send_poll(poll_item(32'h0000_0010, 1'b0, 2'd0, 1'b0, 7'd0));
    send_poll(poll_item(32'h7FFF_FFFF, 1'b1, MODE_ULTRA, 1'b0, 7'd127));
    send_poll(poll_item(32'h8000_0000, 1'b1, MODE_LOW, 1'b1, 7'h55));
    send_poll(poll_item(32'hAAAA_AAAA, 1'b1, 2'd3, 1'b1, 7'h2A));
    send_poll(poll_item(32'h5555_5555, 1'b0, 2'd2, 1'b0, 7'd0));

    // Zero and one intervals, duty above 100 and zero, thresholds out of order.
    drain();
    cfg_write(REG_SCAN_INTERVAL_LOW, 32'd0);
    cfg_write(REG_SCAN_INTERVAL_ULTRA, 32'd65535);
    cfg_write(REG_ADV_INTERVAL_LOW, 32'd1);
    cfg_write(REG_ADV_INTERVAL_ULTRA, 32'd3);
    cfg_write(REG_DUTY_LOW, 32'd127);
    cfg_write(REG_DUTY_ULTRA, 32'd0);
    cfg_write(REG_BATT_ULTRA_THR, 32'd80);
    cfg_write(REG_BATT_LOW_THR, 32'd30);
    send_poll(poll_item(32'd10, 1'b1, MODE_LOW, 1'b0, 7'd0));
    send_poll(poll_item(32'd11, 1'b0, 2'd0, 1'b0, 7'd0));
    send_poll(poll_item(32'd11, 1'b0, 2'd0, 1'b0, 7'd0));
    send_poll(poll_item(32'd12, 1'b0, 2'd0, 1'b1, 7'd50));
    send_poll(poll_item(32'd13, 1'b0, 2'd0, 1'b1, 7'd25));
    send_poll(poll_item(32'd20, 1'b0, 2'd0, 1'b1, 7'd100));

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      if (ph == 0) begin
        program_config(0);
      end else if (ph == NumPhases - 1) begin
        program_config(1);
      end else begin
        program_config(2);
      end
      step_max = $urandom_range(1, 100);
      send_poll(poll_item(tick, 1'b1, 2'($urandom_range(MODE_LOW, MODE_ULTRA)), 1'b0, 7'd0));
      for (int n = 0; n < PollsPerPhase; n++) begin
        send_poll(random_poll());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.drained()) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
